@@ rtl/core/adns_pkg.sv @@
`default_nettype none

package adns_pkg;

    // Width of one stored quantization error, Q8.12 in target LSB units.
    localparam int ERR_W = 20;

    // Shaping filter coefficients, Q4.12. Taps past the ninth are zero.
    localparam int COEF_W     = 16;
    localparam int COEF_DEPTH = 16;
    localparam int COEF_IDX_W = 4;

    localparam logic signed [COEF_W-1:0] SHP_COEF [COEF_DEPTH] = '{
        16'sd9880, -16'sd13804, 16'sd16126, -16'sd17097, 16'sd13734,
        -16'sd9032, 16'sd5247, -16'sd2331, 16'sd347,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
    };

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DITHER_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_BITS = 4'd1;

    localparam logic [4:0] TARGET_BITS_RESET = 5'd16;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_RPDF   = 2'd1,
        MODE_TPDF   = 2'd2,
        MODE_SHAPED = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SUM,
        ST_QUANT,
        ST_ERR,
        ST_OUT
    } t_state;

    // Commands from the sequencer to the error history unit.
    typedef struct packed {
        logic clear;
        logic run;
        logic push;
    } t_fir_cmd;

    // Status from the error history unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_fir_stat;

endpackage

`default_nettype wire

@@ rtl/core/adns_fir.sv @@
`default_nettype none

module adns_fir #(
    parameter int SHAPER_TAPS = 9,
    parameter int ACC_W       = 41
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire adns_pkg::t_fir_cmd        i_cmd,
    input  wire logic signed [adns_pkg::ERR_W-1:0] i_push_err,
    output adns_pkg::t_fir_stat            o_stat,
    output logic signed [ACC_W-1:0]        o_acc
);
    import adns_pkg::*;

    localparam int TAP_W  = (SHAPER_TAPS > 1) ? $clog2(SHAPER_TAPS) : 1;
    localparam int CNT_W  = $clog2(SHAPER_TAPS + 1);
    localparam int PROD_W = COEF_W + ERR_W;
    localparam logic [TAP_W-1:0] LAST_ADDR = TAP_W'(SHAPER_TAPS - 1);
    localparam logic [CNT_W-1:0] TAP_COUNT = CNT_W'(SHAPER_TAPS);

    // History memory. The newest error sits at r_head, older ones follow at
    // increasing addresses with wrap. An entry without its valid bit reads as zero.
    logic signed [ERR_W-1:0]  r_mem [SHAPER_TAPS];
    logic [SHAPER_TAPS-1:0]   r_valid;
    logic [TAP_W-1:0]         r_head;
    logic [TAP_W-1:0]         r_rd_ptr;
    logic [CNT_W-1:0]         r_k;
    logic                     r_busy;

    logic signed [ERR_W-1:0]  r_rd_data;
    logic                     r_rd_vld;
    logic [TAP_W-1:0]         r_k1;
    logic                     r_p1;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_p2;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     w_issue;
    logic                     w_done;
    logic [TAP_W-1:0]         w_wr_addr;
    logic signed [ERR_W-1:0]  w_tap_val;

    assign w_issue   = r_busy && (r_k != TAP_COUNT);
    assign w_done    = r_busy && (r_k == TAP_COUNT) && !r_p1 && !r_p2;
    assign w_wr_addr = (r_head == '0) ? LAST_ADDR : r_head - 1'b1;
    assign w_tap_val = r_rd_vld ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[w_wr_addr] <= i_push_err;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_head   <= '0;
            r_rd_ptr <= '0;
            r_k      <= '0;
            r_busy   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_p1     <= 1'b0;
            r_p2     <= 1'b0;
            r_k1     <= '0;
            r_acc    <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (i_cmd.push) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
            if (i_cmd.push) begin
                r_head <= w_wr_addr;
            end

            r_p1 <= w_issue;
            r_p2 <= r_p1;
            if (i_cmd.run) begin
                r_busy   <= 1'b1;
                r_k      <= '0;
                r_rd_ptr <= r_head;
                r_acc    <= '0;
            end else begin
                if (w_issue) begin
                    r_rd_vld <= r_valid[r_rd_ptr];
                    r_k1     <= r_k[TAP_W-1:0];
                    r_k      <= r_k + 1'b1;
                    r_rd_ptr <= (r_rd_ptr == LAST_ADDR) ? '0 : r_rd_ptr + 1'b1;
                end
                if (r_p2) begin
                    r_acc <= r_acc + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
                end
                if (w_done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1) begin
            r_prod <= SHP_COEF[COEF_IDX_W'(r_k1)] * w_tap_val;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = w_done;
    assign o_acc       = r_acc;

endmodule

`default_nettype wire

@@ rtl/core/audio_dither_noise_shaper.sv @@
`default_nettype none

// Channel   Direction  Signals                         Contents
// s_axis    in         tvalid tready tdata tuser       sample, two noise values, start flag
// m_axis    out        tvalid tready tdata             dithered or quantized sample
// cfg       in         valid ready index data          register writes, always ready
//
// A sample in none, rectangular or triangular mode passes from acceptance
// through the SUM and QUANT states until its result is loaded into the output
// register. A noise-shaped sample also waits in MAC and passes through ERR:
// the feedback sum runs through one multiplier and one history memory read
// port, one tap per cycle, behind a two-stage read and multiply pipeline.
// Reset is synchronous and active low; it clears the error history valid bits
// and the control registers, so the history reads as zero without a clearing pass.
// The output register holds one finished transaction; a new input is accepted
// while it waits, and the sequencer stalls only when a second result is ready.

module audio_dither_noise_shaper #(
    parameter int SAMPLE_BITS = 24,
    parameter int SHAPER_TAPS = 9
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // Fields from bit 0: sample_in, noise_a, noise_b, zero padding.
    input  wire logic [((SAMPLE_BITS + 39) / 8) * 8 - 1:0] s_axis_tdata,
    // Field: start_of_buffer.
    input  wire logic                                s_axis_tuser,

    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // Fields from bit 0: sample_out, zero padding.
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,

    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [adns_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [adns_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import adns_pkg::*;

    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
    // Datapath width, in units of 2^-16 sample LSB, with headroom for the
    // largest feedback term.
    localparam int D_W   = SAMPLE_BITS + 32;
    localparam int ACC_W = ERR_W + COEF_W + $clog2(SHAPER_TAPS) + 1;
    localparam int FB_W  = ACC_W - 7;
    localparam int Y_W   = SAMPLE_BITS + 2;
    localparam int SH_W  = $clog2(SAMPLE_BITS);
    localparam int K_W   = $clog2(SAMPLE_BITS + 15);

    localparam logic signed [D_W-1:0] FULL_POS = D_W'(1) <<< (SAMPLE_BITS + 15);
    localparam logic signed [D_W-1:0] FULL_NEG = -FULL_POS;
    localparam logic signed [D_W-1:0] ERR_MAX  = D_W'((1 << (ERR_W - 1)) - 1);
    localparam logic signed [D_W-1:0] ERR_MIN  = -(ERR_MAX + D_W'(1));
    localparam logic signed [D_W-1:0] SMP_MAX  = (D_W'(1) <<< (SAMPLE_BITS - 1)) - D_W'(1);
    localparam logic signed [D_W-1:0] SMP_MIN  = -(SMP_MAX + D_W'(1));

    // Divide by 2^k, rounding half away from zero; k is at least one.
    function automatic logic signed [D_W-1:0] rnd_shift(
        input logic signed [D_W-1:0] v,
        input logic [K_W-1:0]        k
    );
        logic signed [D_W-1:0] half;
        logic signed [D_W-1:0] sum;
        half = D_W'(1) <<< (k - 1'b1);
        sum  = v + half - $signed({{(D_W - 1){1'b0}}, v[D_W-1]});
        return sum >>> k;
    endfunction

    // Configuration registers.
    t_mode                   r_dither_mode;
    logic [4:0]              r_target_bits;

    // Sequencer and datapath registers.
    t_state                  r_state;
    t_state                  n_state;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [15:0]      r_na;
    logic signed [15:0]      r_nb;
    logic signed [FB_W-1:0]  r_fb;
    logic signed [D_W-1:0]   r_d;
    logic signed [Y_W-1:0]   r_y;
    logic [SAMPLE_BITS-1:0]  r_out_sample;
    logic                    r_out_valid;

    t_fir_cmd                w_cmd;
    t_fir_stat               w_stat;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [ERR_W-1:0] w_err;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic [SH_W-1:0]         w_shift;
    logic signed [16:0]      w_noise;
    logic signed [D_W-1:0]   w_fb_full;
    logic signed [D_W-1:0]   w_d_next;
    logic signed [D_W-1:0]   w_y_next;
    logic signed [D_W-1:0]   w_y_ext;
    logic signed [D_W-1:0]   w_y_sat;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dither_mode <= MODE_NONE;
            r_target_bits <= TARGET_BITS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_DITHER_MODE) begin
                r_dither_mode <= t_mode'(i_cfg_data[1:0]);
            end else if (i_cfg_index == REG_TARGET_BITS) begin
                r_target_bits <= i_cfg_data[4:0];
            end
        end
    end

    // The target LSB is 2^w_shift sample LSBs, with the word length clamped
    // to the range the datapath supports.
    always_comb begin
        int tb;
        tb = int'(r_target_bits);
        if (tb < 2) begin
            tb = 2;
        end
        if (tb > SAMPLE_BITS) begin
            tb = SAMPLE_BITS;
        end
        w_shift = SH_W'(SAMPLE_BITS - tb);
    end

    always_comb begin
        logic signed [D_W-1:0] x_ext;
        logic signed [D_W-1:0] n_ext;
        logic signed [D_W-1:0] fb_ext;
        logic signed [D_W-1:0] acc_ext;
        logic signed [D_W-1:0] clamped;
        logic signed [D_W-1:0] diff;
        logic signed [D_W-1:0] e_rnd;

        x_ext   = r_x;
        acc_ext = w_acc;
        fb_ext  = r_fb;

        if (r_dither_mode == MODE_RPDF) begin
            w_noise = $signed({r_na[15], r_na});
        end else begin
            w_noise = $signed({r_na[15], r_na}) + $signed({r_nb[15], r_nb});
        end
        n_ext = w_noise;

        // Feedback sum is Q.24 in target LSB units; bring it to Q.16.
        w_fb_full = rnd_shift(acc_ext, K_W'(8));

        w_d_next = (x_ext <<< 16) + (n_ext <<< w_shift) + (fb_ext <<< w_shift);

        // Shaped mode clamps to full scale, then quantizes to the target grid.
        if (r_d > FULL_POS) begin
            clamped = FULL_POS;
        end else if (r_d < FULL_NEG) begin
            clamped = FULL_NEG;
        end else begin
            clamped = r_d;
        end

        unique case (r_dither_mode)
            MODE_NONE:   w_y_next = x_ext;
            MODE_RPDF,
            MODE_TPDF:   w_y_next = rnd_shift(r_d, K_W'(16));
            MODE_SHAPED: w_y_next = rnd_shift(clamped, K_W'(w_shift) + K_W'(16)) <<< w_shift;
            default:     w_y_next = x_ext;
        endcase

        // The error uses the unclamped sum and the quantized value before the
        // result is saturated to the sample range.
        w_y_ext = r_y;
        diff    = r_d - (w_y_ext <<< 16);
        e_rnd   = rnd_shift(diff, K_W'(w_shift) + K_W'(4));
        if (e_rnd > ERR_MAX) begin
            w_err = ERR_MAX[ERR_W-1:0];
        end else if (e_rnd < ERR_MIN) begin
            w_err = ERR_MIN[ERR_W-1:0];
        end else begin
            w_err = e_rnd[ERR_W-1:0];
        end

        if (w_y_ext > SMP_MAX) begin
            w_y_sat = SMP_MAX;
        end else if (w_y_ext < SMP_MIN) begin
            w_y_sat = SMP_MIN;
        end else begin
            w_y_sat = w_y_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    w_cmd.clear = s_axis_tuser;
                    w_cmd.run   = (r_dither_mode == MODE_SHAPED);
                    n_state     = (r_dither_mode == MODE_SHAPED) ? ST_MAC : ST_SUM;
                end
            end
            ST_MAC: begin
                if (w_stat.done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_QUANT;
            end
            ST_QUANT: begin
                n_state = (r_dither_mode == MODE_SHAPED) ? ST_ERR : ST_OUT;
            end
            ST_ERR: begin
                w_cmd.push = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x  <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_na <= s_axis_tdata[SAMPLE_BITS+15:SAMPLE_BITS];
            r_nb <= s_axis_tdata[SAMPLE_BITS+31:SAMPLE_BITS+16];
            r_fb <= '0;
        end
        if (r_state == ST_MAC && w_stat.done) begin
            r_fb <= w_fb_full[FB_W-1:0];
        end
        if (r_state == ST_SUM) begin
            r_d <= w_d_next;
        end
        if (r_state == ST_QUANT) begin
            r_y <= w_y_next[Y_W-1:0];
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_out_sample <= w_y_sat[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    adns_fir #(
        .SHAPER_TAPS (SHAPER_TAPS),
        .ACC_W       (ACC_W)
    ) u_fir (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_push_err (w_err),
        .o_stat     (w_stat),
        .o_acc      (w_acc)
    );

    // One transaction at a time: the input closes right after an acceptance.
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a sample was in flight");

    // The feedback sum completes only while the sequencer waits for it.
    a_done_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == ST_MAC))
        else $error("feedback sum finished outside its wait state");

    // The history unit is idle once the sequencer moves past the feedback sum.
    a_fir_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM || r_state == ST_QUANT || r_state == ST_ERR) |-> !w_stat.busy)
        else $error("history unit still busy after the feedback sum");

    // A new result appears only when the sequencer hands it over.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_OUT))
        else $error("result appeared without a handover");

endmodule

`default_nettype wire
